/* rtl/cfbl_pkg.sv */
package cfbl_pkg;

    localparam int unsigned ID_W       = 11;
    localparam int unsigned DLC_W      = 4;
    localparam int unsigned PAY_W      = 64;
    localparam int unsigned CRC_W      = 15;
    localparam int unsigned STUFF_W    = 5;
    localparam int unsigned LEN_W      = 8;
    localparam int unsigned RUN_W      = 3;

    localparam logic [CRC_W-1:0] CRC_POLY = 15'h4599;

    // SOF + identifier + RTR/IDE/r0 + length code
    localparam int unsigned HDR_BITS   = 1 + ID_W + 3 + DLC_W;
    localparam int unsigned SHIFT_W    = HDR_BITS + PAY_W;
    localparam int unsigned CNT_W      = 7;
    localparam int unsigned MAX_BYTES  = 8;
    localparam int unsigned STUFF_RUN  = 5;
    // CRC delimiter, ACK slot, ACK delimiter, EOF
    localparam int unsigned TAIL_BITS  = 3 + 7;

    typedef struct packed {
        logic clear;
        logic shift;
        logic crc_en;
    } t_bit_ctrl;

endpackage

/* rtl/cfbl_if.sv */
interface cfbl_in_if;
    logic                          valid;
    logic                          ready;
    logic [cfbl_pkg::ID_W-1:0]     identifier;
    logic [cfbl_pkg::DLC_W-1:0]    data_length;
    logic [cfbl_pkg::PAY_W-1:0]    payload;

    modport source (output valid, identifier, data_length, payload, input ready);
    modport sink   (input valid, identifier, data_length, payload, output ready);
endinterface

interface cfbl_out_if;
    logic                          valid;
    logic                          ready;
    logic [cfbl_pkg::CRC_W-1:0]    crc_value;
    logic [cfbl_pkg::STUFF_W-1:0]  stuff_count;
    logic [cfbl_pkg::LEN_W-1:0]    frame_length;

    modport source (output valid, crc_value, stuff_count, frame_length, input ready);
    modport sink   (input valid, crc_value, stuff_count, frame_length, output ready);
endinterface

/* rtl/cfbl_bit_unit.sv */
module cfbl_bit_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cfbl_pkg::t_bit_ctrl          i_ctrl,
    input  logic                         i_bit,
    output logic [cfbl_pkg::CRC_W-1:0]   o_crc,
    output logic [cfbl_pkg::STUFF_W-1:0] o_stuff
);
    import cfbl_pkg::*;

    logic [CRC_W-1:0]   r_crc,   n_crc;
    logic [RUN_W-1:0]   r_run,   n_run;
    logic               r_prev,  n_prev;
    logic [STUFF_W-1:0] r_stuff, n_stuff;
    logic [RUN_W-1:0]   w_run;

    always_comb begin
        n_crc   = r_crc;
        n_run   = r_run;
        n_prev  = r_prev;
        n_stuff = r_stuff;
        w_run   = (i_bit == r_prev) ? r_run + RUN_W'(1) : RUN_W'(1);
        if (i_ctrl.clear) begin
            n_crc   = '0;
            n_run   = '0;
            n_prev  = 1'b1;
            n_stuff = '0;
        end else if (i_ctrl.shift) begin
            if (i_ctrl.crc_en) begin
                n_crc = {r_crc[CRC_W-2:0], 1'b0} ^
                        ((i_bit ^ r_crc[CRC_W-1]) ? CRC_POLY : '0);
            end
            if (w_run == RUN_W'(STUFF_RUN)) begin
                // stuffed bit is the complement and opens a new run
                n_stuff = r_stuff + STUFF_W'(1);
                n_prev  = ~i_bit;
                n_run   = RUN_W'(1);
            end else begin
                n_prev  = i_bit;
                n_run   = w_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= '0;
            r_run   <= '0;
            r_prev  <= 1'b1;
            r_stuff <= '0;
        end else begin
            r_crc   <= n_crc;
            r_run   <= n_run;
            r_prev  <= n_prev;
            r_stuff <= n_stuff;
        end
    end

    assign o_crc   = r_crc;
    assign o_stuff = r_stuff;

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run < RUN_W'(STUFF_RUN))
        else $error("stuff run tracker reached a full run");

endmodule

/* rtl/can_frame_bit_length_top.sv */
// Bits pass one per cycle through the shared CRC/stuff unit: 19 + 8*N header and
// data bits (N = payload bytes, 0..8), then the CRC is loaded, then 15 CRC bits,
// then the result is registered once the output slot is free.
// One frame at a time: input ready only while idle.
// Synchronous active-low reset clears the sequencer and the result valid flag.
module can_frame_bit_length_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfbl_in_if.sink     i_in,
    cfbl_out_if.source  o_out
);
    import cfbl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DATA,
        S_LOAD,
        S_CRC,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [CNT_W-1:0]   r_seq,   n_seq;
    logic               r_valid, n_valid;
    logic [CRC_W-1:0]   r_crc_o, n_crc_o;
    logic [STUFF_W-1:0] r_stf_o, n_stf_o;
    logic [LEN_W-1:0]   r_len_o, n_len_o;

    t_bit_ctrl          w_ctrl;
    logic [CRC_W-1:0]   w_crc;
    logic [STUFF_W-1:0] w_stuff;
    logic [DLC_W-1:0]   w_nbytes;
    logic [CNT_W-1:0]   w_hdr_len;

    cfbl_bit_unit u_bit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_bit   (r_shift[SHIFT_W-1]),
        .o_crc   (w_crc),
        .o_stuff (w_stuff)
    );

    assign w_nbytes  = (i_in.data_length > DLC_W'(MAX_BYTES)) ? DLC_W'(MAX_BYTES)
                                                              : i_in.data_length;
    assign w_hdr_len = CNT_W'(HDR_BITS) + {w_nbytes, 3'b000};

    always_comb begin
        n_state = r_state;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_seq   = r_seq;
        n_crc_o = r_crc_o;
        n_stf_o = r_stf_o;
        n_len_o = r_len_o;
        n_valid = r_valid & ~o_out.ready;
        w_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_shift      = {1'b0, i_in.identifier, 3'b000, i_in.data_length,
                                    i_in.payload};
                    n_cnt        = w_hdr_len;
                    n_seq        = w_hdr_len + CNT_W'(CRC_W);
                    w_ctrl.clear = 1'b1;
                    n_state      = S_DATA;
                end
            end
            S_DATA: begin
                w_ctrl.shift  = 1'b1;
                w_ctrl.crc_en = 1'b1;
                n_shift       = r_shift << 1;
                n_cnt         = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_shift = {w_crc, (SHIFT_W-CRC_W)'(0)};
                n_cnt   = CNT_W'(CRC_W);
                n_state = S_CRC;
            end
            S_CRC: begin
                w_ctrl.shift = 1'b1;
                n_shift      = r_shift << 1;
                n_cnt        = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_valid || o_out.ready) begin
                    n_valid = 1'b1;
                    n_crc_o = w_crc;
                    n_stf_o = w_stuff;
                    n_len_o = LEN_W'(r_seq) + LEN_W'(w_stuff) + LEN_W'(TAIL_BITS);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
        r_shift <= n_shift;
        r_seq   <= n_seq;
        r_crc_o <= n_crc_o;
        r_stf_o <= n_stf_o;
        r_len_o <= n_len_o;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_valid;
    assign o_out.crc_value    = r_crc_o;
    assign o_out.stuff_count  = r_stf_o;
    assign o_out.frame_length = r_len_o;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_state == S_DATA)
        else $error("accepted beat did not start the bit pass");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA || r_state == S_CRC) |-> r_cnt != '0)
        else $error("bit counter empty during shift phase");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside the done step");

endmodule

/* tb/can_frame_bit_length_top_tb.sv */
`timescale 1ns / 100ps

module can_frame_bit_length_top_tb;

    import cfbl_pkg::*;

    localparam int unsigned MAX_SEQ        = HDR_BITS + PAY_W + CRC_W;
    localparam int unsigned RANDOM_FRAMES  = 1850;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 200;
    localparam int unsigned HOLD_CYCLES    = 800;

    typedef struct packed {
        logic [ID_W-1:0]  identifier;
        logic [DLC_W-1:0] data_length;
        logic [PAY_W-1:0] payload;
    } t_frame_in;

    typedef struct packed {
        logic [CRC_W-1:0]   crc_value;
        logic [STUFF_W-1:0] stuff_count;
        logic [LEN_W-1:0]   frame_length;
    } t_frame_bits;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_EVERY4,
        RX_SPARSE
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cfbl_in_if  in_if ();
    cfbl_out_if out_if ();

    can_frame_bit_length_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_frame_in   pending_frames [$];
    t_frame_bits expected_frames [$];
    int unsigned errors = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_frame_bits calc_frame_bits(input t_frame_in f);
        bit               seq [MAX_SEQ];
        int unsigned      n;
        int unsigned      nbytes;
        int unsigned      stuff;
        int unsigned      run;
        logic [CRC_W-1:0] crc;
        bit               prev;
        bit               fb;
        t_frame_bits      r;
        n = 0;
        seq[n] = 1'b0;
        n++;
        for (int k = ID_W - 1; k >= 0; k--) begin
            seq[n] = f.identifier[k];
            n++;
        end
        // RTR, IDE, r0
        for (int k = 0; k < 3; k++) begin
            seq[n] = 1'b0;
            n++;
        end
        for (int k = DLC_W - 1; k >= 0; k--) begin
            seq[n] = f.data_length[k];
            n++;
        end
        nbytes = (f.data_length > MAX_BYTES) ? MAX_BYTES : f.data_length;
        for (int i = 0; i < nbytes; i++) begin
            for (int k = 7; k >= 0; k--) begin
                seq[n] = f.payload[PAY_W - 8 - 8 * i + k];
                n++;
            end
        end
        crc = '0;
        for (int i = 0; i < n; i++) begin
            fb  = seq[i] ^ crc[CRC_W-1];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        for (int k = CRC_W - 1; k >= 0; k--) begin
            seq[n] = crc[k];
            n++;
        end
        // a stuff bit opens the next run; the bit before SOF counts as 1
        stuff = 0;
        run   = 0;
        prev  = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (seq[i] == prev) begin
                run++;
            end else begin
                run = 1;
            end
            prev = seq[i];
            if (run == STUFF_RUN) begin
                stuff++;
                prev = ~seq[i];
                run  = 1;
            end
        end
        r.crc_value    = crc;
        r.stuff_count  = STUFF_W'(stuff);
        r.frame_length = LEN_W'(n + stuff + TAIL_BITS);
        return r;
    endfunction

    function automatic logic [PAY_W-1:0] rand_payload();
        logic [PAY_W-1:0] p;
        logic [7:0]       b;
        p = '0;
        for (int i = 0; i < MAX_BYTES; i++) begin
            case ($urandom_range(0, 5))
                0:       b = 8'h00;
                1:       b = 8'hff;
                2:       b = ($urandom_range(0, 1) == 0) ? 8'h0f : 8'hf0;
                default: b = 8'($urandom());
            endcase
            p = {p[PAY_W-9:0], b};
        end
        return p;
    endfunction

    task automatic add_frame(input logic [ID_W-1:0] ident, input logic [DLC_W-1:0] dlc,
                             input logic [PAY_W-1:0] pay);
        t_frame_in f;
        f.identifier  = ident;
        f.data_length = dlc;
        f.payload     = pay;
        pending_frames.insert(pending_frames.size(), f);
    endtask

    // sender: bursts with random gaps, valid held until the beat is taken
    int unsigned gap_left   = 0;
    int unsigned burst_left = 1;

    always @(posedge i_clk) begin
        logic accepted;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            gap_left    = 0;
            burst_left  = 1;
        end else begin
            accepted = in_if.valid && in_if.ready;
            if (accepted) begin
                expected_frames.insert(expected_frames.size(),
                                       calc_frame_bits(pending_frames[0]));
                pending_frames.delete(0);
            end
            if (in_if.valid && !accepted) begin
                // hold the offered beat
            end else if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (pending_frames.size() > 0) begin
                in_if.valid       <= 1'b1;
                in_if.identifier  <= pending_frames[0].identifier;
                in_if.data_length <= pending_frames[0].data_length;
                in_if.payload     <= pending_frames[0].payload;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 6);
                    gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 120)
                                                             : $urandom_range(0, 4);
                end else begin
                    burst_left--;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern picked at random from four modes, plus long hold-offs
    int unsigned rx_cycle  = 0;
    int unsigned hold_left = 0;
    t_rx_mode    stall_mode = RX_OPEN;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_cycle     = 0;
            hold_left    = 0;
            stall_mode   = RX_OPEN;
        end else begin
            rx_cycle++;
            if (rx_cycle % 256 == 0) begin
                stall_mode = t_rx_mode'($urandom_range(0, 3));
            end
            if (rx_cycle == 5000 || rx_cycle == 120000) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    RX_OPEN:   out_if.ready <= 1'b1;
                    RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
                    RX_EVERY4: out_if.ready <= (rx_cycle % 4 == 0);
                    default:   out_if.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_frame_bits want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected result: crc %h stuff %0d length %0d", $time,
                         out_if.crc_value, out_if.stuff_count, out_if.frame_length);
                errors++;
            end else begin
                want = expected_frames[0];
                expected_frames.delete(0);
                if (out_if.crc_value !== want.crc_value) begin
                    $display("%0t: crc_value expected %h actual %h", $time,
                             want.crc_value, out_if.crc_value);
                    errors++;
                end
                if (out_if.stuff_count !== want.stuff_count) begin
                    $display("%0t: stuff_count expected %0d actual %0d", $time,
                             want.stuff_count, out_if.stuff_count);
                    errors++;
                end
                if (out_if.frame_length !== want.frame_length) begin
                    $display("%0t: frame_length expected %0d actual %0d", $time,
                             want.frame_length, out_if.frame_length);
                    errors++;
                end
            end
        end
    end

    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d beats pending, %0d results outstanding",
                     $time, pending_frames.size(), expected_frames.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [ID_W-1:0]  ident;
        logic [DLC_W-1:0] dlc;
        i_rst_n = 1'b0;

        // directed frames: field extremes, stuffing extremes, codes above eight
        add_frame(11'h000, 4'd0,  64'h0);
        add_frame(11'h7ff, 4'd0,  64'h0);
        add_frame(11'h000, 4'd8,  64'h0);
        add_frame(11'h7ff, 4'd8,  {PAY_W{1'b1}});
        add_frame(11'h000, 4'd15, 64'h0);
        add_frame(11'h7ff, 4'd9,  {PAY_W{1'b1}});
        add_frame(11'h555, 4'd8,  64'haaaa_aaaa_aaaa_aaaa);
        add_frame(11'h2aa, 4'd4,  64'h5555_5555_5555_5555);
        add_frame(11'h400, 4'd2,  {PAY_W{1'b1}});
        add_frame(11'h001, 4'd1,  64'h8000_0000_0000_0000);
        add_frame(11'h7c0, 4'd3,  64'h0f0f_0f0f_0f0f_0f0f);
        add_frame(11'h03f, 4'd5,  64'hf0f0_f0f0_f0f0_f0f0);
        add_frame(11'h123, 4'd6,  64'h0123_4567_89ab_cdef);
        add_frame(11'h654, 4'd7,  64'hfedc_ba98_7654_3210);
        for (int c = 10; c <= 14; c++) begin
            add_frame(11'($urandom()), DLC_W'(c), {$urandom(), $urandom()});
        end
        add_frame(11'h7ff, 4'd15, 64'h0);
        add_frame(11'h000, 4'd12, {PAY_W{1'b1}});

        for (int i = 0; i < RANDOM_FRAMES; i++) begin
            case ($urandom_range(0, 9))
                0:       ident = '0;
                1:       ident = '1;
                default: ident = 11'($urandom());
            endcase
            if ($urandom_range(0, 3) == 0) begin
                dlc = DLC_W'($urandom_range(9, 15));
            end else begin
                dlc = DLC_W'($urandom_range(0, 8));
            end
            add_frame(ident, dlc, rand_payload());
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_frames.size() != 0 || expected_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && expected_frames.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/cfbl_pkg.sv
rtl/cfbl_if.sv
rtl/cfbl_bit_unit.sv
rtl/can_frame_bit_length_top.sv
tb/can_frame_bit_length_top_tb.sv
